// ===== sv/sgm_pkg.sv =====
// Shared types and constants for the Scharr gradient magnitude block.
`timescale 1ns / 1ps
package sgm_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned PixelBitsDef = 8;
  localparam int unsigned QueueDepth   = 4;

  // Row geometry
  localparam int unsigned RowLimit = 4096;
  localparam int unsigned RowW     = 12;   // row counter, holds 0..RowLimit-1
  localparam int unsigned HeightW  = 13;   // frame_height register
  localparam int unsigned WidthW   = 12;   // frame_width register
  localparam int unsigned CfgDataW = 13;   // widest register

  // Result field widths
  localparam int unsigned MagW = 13;
  localparam int unsigned PixOutW = 8;

  // Register indexes
  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  // Per-request status that travels alongside the gradients
  typedef struct packed {
    logic interior;   // result pixel is not on the border
    logic last;       // request carries the frame's final pixel
  } sgm_flags_t;

endpackage

// ===== sv/sgm_queue.sv =====
// Small register queue between the window front end and the root back end.
`timescale 1ns / 1ps
module sgm_queue
  import sgm_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LvlW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o,
  output logic [LvlW-1:0]  level_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign empty_o = (level_q == '0);
  assign full_o  = (level_q == LvlW'(DEPTH));
  assign level_o = level_q;

endmodule

// ===== sv/sgm_front.sv =====
// Front end: raster counters, two line stores, 3x3 window and Scharr gradients.
`timescale 1ns / 1ps
module sgm_front
  import sgm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned PIXEL_BITS = PixelBitsDef,
  parameter int unsigned Q_DEPTH    = QueueDepth,
  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1),
  localparam int unsigned GW   = PIXEL_BITS + 5,
  localparam int unsigned LvlW = $clog2(Q_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [WidthW-1:0]      frame_width_i,
  input  logic [HeightW-1:0]     frame_height_i,
  input  logic                   push_i,
  input  logic [PIXEL_BITS-1:0]  pixel_i,
  output logic                   full_o,
  input  logic [LvlW-1:0]        q_level_i,
  output logic                   grad_push_o,
  output logic signed [GW-1:0]   gx_o,
  output logic signed [GW-1:0]   gy_o,
  output sgm_flags_t             flags_o
);

  localparam int unsigned ReserveW = LvlW + 2;

  // Line stores
  logic [PIXEL_BITS-1:0] line_a_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] line_b_mem [MAX_WIDTH];

  logic                  accept;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [WW-1:0]         w_eff;
  logic [HeightW-1:0]    h_eff;
  logic [WW-1:0]         col_inc;
  logic [HeightW-1:0]    row_inc;
  logic                  row_end, frame_end;
  sgm_flags_t            flags_s0;

  // stage 1: line-store read data is back
  logic                  s1_v_q;
  logic [ColW-1:0]       idx_s1_q;
  logic [PIXEL_BITS-1:0] px_s1_q;
  logic [PIXEL_BITS-1:0] rd_a_q, rd_b_q;
  sgm_flags_t            flags_s1_q;

  // stage 2: window updated, gradients formed
  logic                  s2_v_q;
  sgm_flags_t            flags_s2_q;
  logic [PIXEL_BITS-1:0] win_q [3][3];

  logic [ReserveW-1:0]   reserved;

  // Effective geometry
  always_comb begin
    if (frame_width_i < WidthW'(3)) begin
      w_eff = WW'(3);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_i);
    end
    if (frame_height_i < HeightW'(3)) begin
      h_eff = HeightW'(3);
    end else if (32'(frame_height_i) > 32'(RowLimit)) begin
      h_eff = HeightW'(RowLimit);
    end else begin
      h_eff = frame_height_i;
    end
  end

  // queue slots already spoken for by requests still in flight
  assign reserved = ReserveW'(q_level_i) + ReserveW'(s1_v_q) + ReserveW'(s2_v_q);
  assign full_o   = (reserved >= ReserveW'(Q_DEPTH));
  assign accept   = push_i && !full_o;

  assign col_inc   = WW'({1'b0, col_q}) + WW'(1);
  assign row_inc   = HeightW'(row_q) + HeightW'(1);
  assign row_end   = (col_inc >= w_eff);
  assign frame_end = (row_inc >= h_eff);

  assign flags_s0.interior = (col_q >= ColW'(2)) && (row_q >= RowW'(2)) &&
                             (WW'({1'b0, col_q}) < w_eff) &&
                             (HeightW'(row_q) < h_eff);
  assign flags_s0.last     = row_end && frame_end;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_inc[RowW-1:0];
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= rd_b_q;
        win_q[1][2] <= rd_a_q;
        win_q[2][2] <= px_s1_q;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_s1_q   <= col_q;
      px_s1_q    <= pixel_i;
      flags_s1_q <= flags_s0;
    end
    if (s1_v_q) begin
      flags_s2_q <= flags_s1_q;
    end
  end

  // line stores: read on accept, written back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= line_a_mem[col_q];
      rd_b_q <= line_b_mem[col_q];
    end
    if (s1_v_q) begin
      line_a_mem[idx_s1_q] <= px_s1_q;
      line_b_mem[idx_s1_q] <= rd_a_q;
    end
  end

  // 3*(a-b) + 10*(c-d) + 3*(e-f)
  function automatic logic signed [GW-1:0] scharr_sum(
    input logic [PIXEL_BITS-1:0] a, input logic [PIXEL_BITS-1:0] b,
    input logic [PIXEL_BITS-1:0] c, input logic [PIXEL_BITS-1:0] d,
    input logic [PIXEL_BITS-1:0] e, input logic [PIXEL_BITS-1:0] f);
    logic signed [GW-1:0] d0, d1, d2;
    d0 = signed'(GW'(a)) - signed'(GW'(b));
    d1 = signed'(GW'(c)) - signed'(GW'(d));
    d2 = signed'(GW'(e)) - signed'(GW'(f));
    return (d0 <<< 1) + d0 + (d1 <<< 3) + (d1 <<< 1) + (d2 <<< 1) + d2;
  endfunction

  assign gx_o = scharr_sum(win_q[0][2], win_q[0][0], win_q[1][2], win_q[1][0],
                           win_q[2][2], win_q[2][0]);
  assign gy_o = scharr_sum(win_q[2][0], win_q[0][0], win_q[2][1], win_q[0][1],
                           win_q[2][2], win_q[0][2]);
  assign grad_push_o = s2_v_q;
  assign flags_o     = flags_s2_q;

endmodule

// ===== sv/sgm_back.sv =====
// Back end: squares, bit-pair square root and the result register.
`timescale 1ns / 1ps
module sgm_back
  import sgm_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PixelBitsDef,
  localparam int unsigned GW    = PIXEL_BITS + 5,
  localparam int unsigned SW    = 2 * PIXEL_BITS + 9,
  localparam int unsigned Steps = (SW + 1) / 2,
  localparam int unsigned RW    = 2 * Steps,
  localparam int unsigned StepW = $clog2(Steps)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  logic signed [GW-1:0] gx_i,
  input  logic signed [GW-1:0] gy_i,
  input  sgm_flags_t           flags_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic                 out_valid_o,
  output logic [MagW-1:0]      magnitude_o,
  output logic [PixOutW-1:0]   pixel_out_o,
  output logic                 frame_last_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSqr  = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StIter = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]            state_q, state_d;
  logic signed [GW-1:0]  gx_q, gy_q;
  sgm_flags_t            flags_q;
  logic [SW-1:0]         sqx_q, sqy_q;
  logic signed [2*GW-1:0] prod_x, prod_y;
  logic [RW:0]           rad_q, rad_d;
  logic [RW:0]           res_q, res_d;
  logic [RW:0]           bit_q, bit_d;
  logic [RW:0]           trial;
  logic [StepW-1:0]      step_q, step_d;
  logic [Steps-1:0]      root;
  logic                  out_v_q, out_v_d;
  logic                  load_out;
  logic                  out_free;

  assign prod_x = gx_q * gx_q;
  assign prod_y = gy_q * gy_q;
  assign trial  = res_q + bit_q;
  assign root   = res_q[Steps-1:0];

  assign out_free = !out_v_q || pop_i;
  assign q_pop_o  = (state_q == StIdle) && !q_empty_i;
  assign load_out = (state_q == StDone) && out_free;

  always_comb begin
    state_d = state_q;
    rad_d   = rad_q;
    res_d   = res_q;
    bit_d   = bit_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (!q_empty_i) begin
          state_d = StSqr;
        end
      end
      StSqr: begin
        state_d = StSum;
      end
      StSum: begin
        rad_d   = (RW + 1)'(sqx_q) + (RW + 1)'(sqy_q);
        res_d   = '0;
        bit_d   = (RW + 1)'(1) << (2 * (Steps - 1));
        step_d  = '0;
        state_d = StIter;
      end
      StIter: begin
        if (rad_q >= trial) begin
          rad_d = rad_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(Steps - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (load_out) begin
      out_v_d = 1'b1;
    end else if (pop_i && out_v_q) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    step_q <= step_d;
    if (q_pop_o) begin
      gx_q    <= gx_i;
      gy_q    <= gy_i;
      flags_q <= flags_i;
    end
    if (state_q == StSqr) begin
      sqx_q <= prod_x[SW-1:0];
      sqy_q <= prod_y[SW-1:0];
    end
    if (load_out) begin
      out_valid_o  <= flags_q.interior;
      frame_last_o <= flags_q.last;
      magnitude_o  <= MagW'(root);
      pixel_out_o  <= (root > Steps'(255)) ? PixOutW'(255) : PixOutW'(root);
    end
  end

  assign empty_o = !out_v_q;

endmodule

// ===== sv/scharr_gradient_magnitude.sv =====
// Top level of the Scharr 3x3 gradient magnitude block.
// The bit-pair root unit works on one request at a time; the queue holds further requests
// while it is busy.
// Reset (rst_ni low, asynchronous) clears counters, window, queue and the result valid flag;
// line stores are not cleared and geometry returns to 640 x 480.
`timescale 1ns / 1ps
module scharr_gradient_magnitude
  import sgm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  // pixel requests
  input  logic                  push,
  output logic                  full,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  // results
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_valid_o,
  output logic [MagW-1:0]       magnitude_o,
  output logic [PixOutW-1:0]    pixel_out_o,
  output logic                  frame_last_o
);

  localparam int unsigned GW   = PIXEL_BITS + 5;
  localparam int unsigned QW   = 2 * GW + $bits(sgm_flags_t);
  localparam int unsigned LvlW = $clog2(QueueDepth + 1);

  // Geometry registers
  logic [WidthW-1:0]  frame_width_q;
  logic [HeightW-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthW'(640);
      frame_height_q <= HeightW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  frame_width_q  <= cfg_wdata_i[WidthW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front end -> queue
  logic                 grad_push;
  logic signed [GW-1:0] front_gx, front_gy;
  sgm_flags_t           front_flags;
  logic [LvlW-1:0]      q_level;
  logic                 q_full, q_empty, q_pop;
  logic [QW-1:0]        q_wdata, q_rdata;

  // Queue -> back end
  logic signed [GW-1:0] back_gx, back_gy;
  sgm_flags_t           back_flags;

  sgm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .Q_DEPTH    (QueueDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .push_i         (push),
    .pixel_i        (pixel_in_i),
    .full_o         (full),
    .q_level_i      (q_level),
    .grad_push_o    (grad_push),
    .gx_o           (front_gx),
    .gy_o           (front_gy),
    .flags_o        (front_flags)
  );

  assign q_wdata = {front_flags, front_gx, front_gy};

  // Front reserves a slot per request in flight, so the push never meets a full queue
  sgm_queue #(
    .DEPTH (QueueDepth),
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grad_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full),
    .level_o (q_level)
  );

  assign back_flags = q_rdata[QW-1 -: $bits(sgm_flags_t)];
  assign back_gx    = q_rdata[2*GW-1 -: GW];
  assign back_gy    = q_rdata[GW-1:0];

  sgm_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .gx_i         (back_gx),
    .gy_i         (back_gy),
    .flags_i      (back_flags),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_valid_o  (out_valid_o),
    .magnitude_o  (magnitude_o),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

`ifndef SYNTHESIS
  // slot reservation must keep the queue from overflowing
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    grad_push |-> !q_full)
    else $error("gradient request pushed into a full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  // a full queue must hold the pixel input off
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> full)
    else $error("pixel input open while queue is full");
`endif

endmodule
